// ===== hw/rtl/touch_frame_to_mt_events_defines.svh =====
// assertion macros for the touch frame to multitouch event block
// used by the top level; expects clk_i and rst_ni in scope
`ifndef TOUCH_FRAME_TO_MT_EVENTS_DEFINES_SVH
`define TOUCH_FRAME_TO_MT_EVENTS_DEFINES_SVH

// property that must hold at every edge outside reset
`define TFMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define TFMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tfmt_pkg.sv =====
// shared types and constants of the touch frame to multitouch event block
// no dependencies
`timescale 1ns / 1ps

package tfmt_pkg;

  typedef enum logic [2:0] {
    EV_SLOT       = 3'd0,
    EV_TRACK_ID   = 3'd1,
    EV_PRESSURE   = 3'd2,
    EV_POS_X      = 3'd3,
    EV_POS_Y      = 3'd4,
    EV_TOUCH_KEY  = 3'd5,
    EV_TOOL_KEY   = 3'd6,
    EV_SYNC       = 3'd7
  } event_kind_e;

  // positions in the pending event mask, in emission order
  localparam int unsigned NumEvBits   = 9;
  localparam int unsigned SlotBit     = 0;
  localparam int unsigned TrackBit    = 1;
  localparam int unsigned PressBit    = 2;
  localparam int unsigned PosXBit     = 3;
  localparam int unsigned PosYBit     = 4;
  localparam int unsigned TouchBit    = 5;
  localparam int unsigned ToolABit    = 6;
  localparam int unsigned ToolBBit    = 7;
  localparam int unsigned SyncBit     = 8;

  localparam logic [15:0] NO_CONTACT    = 16'hFFFF;
  localparam logic [16:0] TRACK_NONE    = 17'h1FFFF;
  localparam logic [16:0] FULL_PRESSURE = 17'd255;
  localparam logic [2:0]  MAX_FINGERS   = 3'd5;

  // events of one item, worked out at once and emitted one per cycle while the output is ready
  typedef struct packed {
    logic [NumEvBits-1:0] mask;
    logic [3:0]           slot;
    logic [15:0]          track_id;
    logic                 contact;
    logic signed [15:0]   pos_x;
    logic signed [15:0]   pos_y;
    logic                 touch_on;
    logic [2:0]           tool_a_fingers;
    logic                 tool_a_on;
    logic [2:0]           tool_b_fingers;
    logic                 tool_b_on;
  } plan_t;

endpackage

// ===== hw/rtl/tfmt_in_if.sv =====
// input channel of the touch frame to multitouch event block: one touch point per item
// no dependencies
`timescale 1ns / 1ps

interface tfmt_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         touch_index;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               frame_end;

  modport source (output valid, touch_index, pos_x, pos_y, frame_end, input ready);
  modport sink   (input valid, touch_index, pos_x, pos_y, frame_end, output ready);
endinterface

// ===== hw/rtl/tfmt_out_if.sv =====
// output channel of the touch frame to multitouch event block: one event per item
// no dependencies
`timescale 1ns / 1ps

interface tfmt_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_kind;
  logic signed [16:0] event_value;
  logic [2:0]         tool_fingers;
  logic               last_event;

  modport source (output valid, event_kind, event_value, tool_fingers, last_event,
                  input ready);
  modport sink   (input valid, event_kind, event_value, tool_fingers, last_event,
                  output ready);
endinterface

// ===== hw/rtl/tfmt_emit.sv =====
// event serializer: holds the pending events of one item and sends one per cycle while the output is ready
// depends on tfmt_pkg and tfmt_out_if
`timescale 1ns / 1ps

module tfmt_emit import tfmt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              plan_valid_i,
  input  plan_t             plan_i,
  output logic              plan_ready_o,
  tfmt_out_if.source        events_o
);

  plan_t                ev_q, ev_d;
  logic [NumEvBits-1:0] low, mask_after;
  logic                 out_free, pop, load;

  logic                 out_valid_q, out_valid_d;
  event_kind_e          kind_q, kind_d;
  logic signed [16:0]   value_q, value_d;
  logic [2:0]           fingers_q, fingers_d;
  logic                 last_q;

  assign out_free     = !out_valid_q || events_o.ready;
  assign pop          = (ev_q.mask != '0) && out_free;
  assign low          = ev_q.mask & (~ev_q.mask + NumEvBits'(1));
  assign mask_after   = pop ? (ev_q.mask & ~low) : ev_q.mask;
  assign plan_ready_o = (mask_after == '0);
  assign load         = plan_valid_i && plan_ready_o;

  always_comb begin
    ev_d      = ev_q;
    ev_d.mask = mask_after;
    if (load) begin
      ev_d = plan_i;
    end
  end

  // lowest pending event goes first
  always_comb begin
    kind_d    = EV_SYNC;
    value_d   = '0;
    fingers_d = '0;
    if (ev_q.mask[SlotBit]) begin
      kind_d  = EV_SLOT;
      value_d = {13'b0, ev_q.slot};
    end else if (ev_q.mask[TrackBit]) begin
      kind_d  = EV_TRACK_ID;
      value_d = ev_q.contact ? {1'b0, ev_q.track_id} : TRACK_NONE;
    end else if (ev_q.mask[PressBit]) begin
      kind_d  = EV_PRESSURE;
      value_d = ev_q.contact ? FULL_PRESSURE : '0;
    end else if (ev_q.mask[PosXBit]) begin
      kind_d  = EV_POS_X;
      value_d = {ev_q.pos_x[15], ev_q.pos_x};
    end else if (ev_q.mask[PosYBit]) begin
      kind_d  = EV_POS_Y;
      value_d = {ev_q.pos_y[15], ev_q.pos_y};
    end else if (ev_q.mask[TouchBit]) begin
      kind_d  = EV_TOUCH_KEY;
      value_d = {16'b0, ev_q.touch_on};
    end else if (ev_q.mask[ToolABit]) begin
      kind_d    = EV_TOOL_KEY;
      value_d   = {16'b0, ev_q.tool_a_on};
      fingers_d = ev_q.tool_a_fingers;
    end else if (ev_q.mask[ToolBBit]) begin
      kind_d    = EV_TOOL_KEY;
      value_d   = {16'b0, ev_q.tool_b_on};
      fingers_d = ev_q.tool_b_fingers;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (events_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ev_q        <= ev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      kind_q    <= kind_d;
      value_q   <= value_d;
      fingers_q <= fingers_d;
      last_q    <= (mask_after == '0);
    end
  end

  assign events_o.valid        = out_valid_q;
  assign events_o.event_kind   = kind_q;
  assign events_o.event_value  = value_q;
  assign events_o.tool_fingers = fingers_q;
  assign events_o.last_event   = last_q;

endmodule

// ===== hw/rtl/touch_frame_to_mt_events.sv =====
// top level: multitouch slot-b event generator over a per-point position memory
// depends on tfmt_pkg, tfmt_in_if, tfmt_out_if, tfmt_emit and the defines header
`timescale 1ns / 1ps
// path: the first event of an item passes the read stage, the serializer's pending register and its output register
// throughput: one event per cycle while the output is ready, set by the single output register
//   of the event serializer; an item (up to 8 events) holds the pipe until its last event is sent
// reset: all points read as no contact through per-entry valid bits, tracking id 0,
//   no slot selected, contact counts 0; no clearing pass, items accepted right away

`include "touch_frame_to_mt_events_defines.svh"

module touch_frame_to_mt_events import tfmt_pkg::*; #(
  parameter int unsigned TOUCH_POINTS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfmt_in_if.sink    touch_i,
  tfmt_out_if.source events_o
);

  localparam int unsigned IdxW = (TOUCH_POINTS > 1) ? $clog2(TOUCH_POINTS) : 1;
  localparam int unsigned CntW = $clog2(TOUCH_POINTS + 1);

  // ---------------------------------------------------------------
  // position memory: {x, y} per point, one write and one read port
  // ---------------------------------------------------------------
  logic [31:0]             mem_q [TOUCH_POINTS];
  logic [TOUCH_POINTS-1:0] valid_q;
  logic [IdxW-1:0]         rd_addr, wr_addr;
  logic [31:0]             wr_data;
  logic                    wr_en;
  logic                    accept;

  // read stage registers: item plus the memory word fetched for it
  logic                    s1_valid_q;
  logic [3:0]              s1_idx_q;
  logic                    s1_in_range_q;
  logic [15:0]             s1_x_q, s1_y_q;
  logic                    s1_fe_q;
  logic [31:0]             rd_data_q;
  logic                    rd_valid_q;
  logic                    fwd_q;
  logic [31:0]             fwd_data_q;
  logic                    s1_take;

  // architectural state
  logic [15:0]             tid_q, tid_d;
  logic [4:0]              sel_q, sel_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         prev_q, prev_d;

  // plan handoff to the serializer
  plan_t                   plan;
  logic                    plan_ready;

  assign accept        = touch_i.valid && touch_i.ready;
  assign touch_i.ready = !s1_valid_q || s1_take;
  assign s1_take       = s1_valid_q && plan_ready;
  assign rd_addr       = touch_i.touch_index[IdxW-1:0];

  assign wr_en   = s1_take && s1_in_range_q;
  assign wr_addr = s1_idx_q[IdxW-1:0];
  assign wr_data = {s1_x_q, s1_y_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // registered read; a write in the same edge to the same point is forwarded
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_data_q     <= mem_q[rd_addr];
      rd_valid_q    <= valid_q[rd_addr];
      fwd_q         <= wr_en && (wr_addr == rd_addr);
      fwd_data_q    <= wr_data;
      s1_idx_q      <= touch_i.touch_index;
      s1_in_range_q <= ({1'b0, touch_i.touch_index} < 5'(TOUCH_POINTS));
      s1_x_q        <= touch_i.pos_x;
      s1_y_q        <= touch_i.pos_y;
      s1_fe_q       <= touch_i.frame_end;
    end
  end

  // ---------------------------------------------------------------
  // point compare against the stored frame
  // ---------------------------------------------------------------
  logic [31:0]     old_word;
  logic [15:0]     px, py;
  logic            dx, dy, old_abs, new_abs;
  logic            pt_change, contact, release_pt, slot_ev;

  always_comb begin
    if (fwd_q) begin
      old_word = fwd_data_q;
    end else if (rd_valid_q) begin
      old_word = rd_data_q;
    end else begin
      old_word = {NO_CONTACT, NO_CONTACT};
    end
  end

  assign px         = old_word[31:16];
  assign py         = old_word[15:0];
  assign dx         = (s1_x_q != px);
  assign dy         = (s1_y_q != py);
  // only all ones in either coordinate means no contact
  assign old_abs    = (px == NO_CONTACT) || (py == NO_CONTACT);
  assign new_abs    = (s1_x_q == NO_CONTACT) || (s1_y_q == NO_CONTACT);
  assign pt_change  = s1_in_range_q && (dx || dy);
  // absent to anything else is a new contact, even absent to another absent value
  assign contact    = pt_change && old_abs;
  assign release_pt = pt_change && !old_abs && new_abs;
  // every point event selects the same slot, so at most one select per item
  assign slot_ev    = pt_change && (sel_q != {1'b0, s1_idx_q});

  // running contact count replaces a sweep over all stored points
  assign cnt_d = cnt_q - CntW'(s1_in_range_q && !old_abs) + CntW'(s1_in_range_q && !new_abs);

  // ---------------------------------------------------------------
  // frame end: touch key, tool keys and sync
  // ---------------------------------------------------------------
  logic       tc_nz, pc_nz, tc_le5, pc_le5, t_hit, p_hit, tool_en, tc_lt_pc;
  logic [2:0] tc3, pc3, fa, fb;

  assign tc_nz    = (cnt_d != '0);
  assign pc_nz    = (prev_q != '0);
  assign tc_le5   = (32'(cnt_d) <= 32'(MAX_FINGERS));
  assign pc_le5   = (32'(prev_q) <= 32'(MAX_FINGERS));
  assign tc3      = 3'(cnt_d);
  assign pc3      = 3'(prev_q);
  assign t_hit    = tc_nz && tc_le5;
  assign p_hit    = pc_nz && pc_le5;
  // tool keys only when the count moved and lands on five fingers or fewer
  assign tool_en  = s1_fe_q && (cnt_d != prev_q) && tc_le5;
  assign tc_lt_pc = (32'(cnt_d) < 32'(prev_q));
  // lower finger count goes first
  assign fa       = (t_hit && p_hit) ? (tc_lt_pc ? tc3 : pc3) : (t_hit ? tc3 : pc3);
  assign fb       = tc_lt_pc ? pc3 : tc3;

  always_comb begin
    plan                  = '0;
    plan.mask[SlotBit]    = slot_ev;
    plan.mask[TrackBit]   = contact || release_pt;
    plan.mask[PressBit]   = contact || release_pt;
    plan.mask[PosXBit]    = s1_in_range_q && dx && !release_pt;
    plan.mask[PosYBit]    = s1_in_range_q && dy && !release_pt;
    plan.mask[TouchBit]   = s1_fe_q && (tc_nz != pc_nz);
    plan.mask[ToolABit]   = tool_en && (t_hit || p_hit);
    plan.mask[ToolBBit]   = tool_en && t_hit && p_hit;
    plan.mask[SyncBit]    = s1_fe_q;
    plan.slot             = s1_idx_q;
    plan.track_id         = tid_q;
    plan.contact          = contact;
    plan.pos_x            = s1_x_q;
    plan.pos_y            = s1_y_q;
    plan.touch_on         = tc_nz;
    plan.tool_a_fingers   = fa;
    plan.tool_a_on        = (fa == tc3);
    plan.tool_b_fingers   = fb;
    plan.tool_b_on        = (fb == tc3);
  end

  // state commits in item order when the plan moves to the serializer
  always_comb begin
    tid_d  = tid_q + 16'(contact);
    sel_d  = pt_change ? {1'b0, s1_idx_q} : sel_q;
    prev_d = s1_fe_q ? cnt_d : prev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_q    <= '0;
      tid_q      <= '0;
      sel_q      <= '1;
      cnt_q      <= '0;
      prev_q     <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_take) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (s1_take) begin
        tid_q  <= tid_d;
        sel_q  <= sel_d;
        cnt_q  <= cnt_d;
        prev_q <= prev_d;
      end
    end
  end

  tfmt_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_valid_i (s1_valid_q),
    .plan_i       (plan),
    .plan_ready_o (plan_ready),
    .events_o     (events_o)
  );

  `TFMT_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_take, s1_valid_q, "read stage item lost")
  `TFMT_ASSERT_NEXT(a_tid_step, s1_take && contact, tid_q == $past(tid_q) + 16'd1,
                    "tracking id did not advance on contact")
  `TFMT_ASSERT_NEXT(a_sel_follow, s1_take && slot_ev, sel_q == {1'b0, $past(s1_idx_q)},
                    "selected slot not updated")
  `TFMT_ASSERT(a_cnt_bound, 32'(cnt_q) <= TOUCH_POINTS, "contact count above point count")

endmodule
